>>> rtl/irt_pkg.sv
// Shared constants, types and lookup functions for the IR remote frame transmitter.
package irt_pkg;

   // Number of accepted key codes; codes at or above it are refused.
   localparam int KEY_COUNT = 22;
   localparam int FRAME_LEN = 48;
   localparam int KEY_WIDTH = 5;
   localparam int PHASE_WIDTH = 5;
   localparam int POS_WIDTH = 6;
   localparam int TICK_WIDTH = 19;

   // Segment phase codes.
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE       = 5'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_START_LOW  = 5'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_START_HIGH = 5'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_ONE_LOW    = 5'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_ONE_HIGH   = 5'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_ZERO_HIGH  = 5'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_TAIL_FIRST = 5'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_TAIL_LAST  = 5'd18;

   // Preamble bytes sent before the key bytes.
   localparam logic [23:0] PREAMBLE = 24'hffaaaa;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic                   level;
      logic [TICK_WIDTH-1:0]  ticks;
   } irt_segment_type;

   typedef struct packed {
      logic rejected;
      logic busy_res;
      logic line_level;
   } irt_result_type;

   // Three key bytes per key code; codes beyond the built-in table give zero bytes.
   function automatic logic [23:0] key_bytes(input logic [KEY_WIDTH-1:0] key);
      logic [23:0] bytes;
      case (key)
         5'd0:    bytes = 24'hffaaaa;
         5'd1:    bytes = 24'hb7bb56;
         5'd2:    bytes = 24'hd7b756;
         5'd3:    bytes = 24'habdf56;
         5'd4:    bytes = 24'hef6b56;
         5'd5:    bytes = 24'hfed556;
         5'd6:    bytes = 24'hafbd56;
         5'd7:    bytes = 24'habfeaa;
         5'd8:    bytes = 24'hb6fb6a;
         5'd9:    bytes = 24'hbbf5aa;
         5'd10:   bytes = 24'hd6f76a;
         5'd11:   bytes = 24'hbafaea;
         5'd12:   bytes = 24'hb5fbaa;
         5'd13:   bytes = 24'hebebaa;
         5'd14:   bytes = 24'hf5eaea;
         5'd15:   bytes = 24'hd56df6;
         5'd16:   bytes = 24'hf7d5aa;
         5'd17:   bytes = 24'heaf5ea;
         5'd18:   bytes = 24'hdadb76;
         5'd19:   bytes = 24'hdf6d56;
         5'd20:   bytes = 24'hddb6b6;
         5'd21:   bytes = 24'hdbb6d6;
         default: bytes = 24'h000000;
      endcase
      return bytes;
   endfunction

   // Line level and length in microseconds of the segment that a phase starts.
   // Any code outside the defined segments returns the idle state.
   function automatic irt_segment_type enter_phase(input logic [PHASE_WIDTH-1:0] phase);
      irt_segment_type seg;
      seg.phase = phase;
      case (phase)
         PH_START_LOW:  begin seg.level = 1'b0; seg.ticks = 19'd8885;    end
         PH_START_HIGH: begin seg.level = 1'b1; seg.ticks = 19'd4456;    end
         PH_ONE_LOW:    begin seg.level = 1'b0; seg.ticks = 19'd533;     end
         PH_ONE_HIGH:   begin seg.level = 1'b1; seg.ticks = 19'd560;     end
         PH_ZERO_HIGH:  begin seg.level = 1'b1; seg.ticks = 19'd1093;    end
         5'd6:          begin seg.level = 1'b0; seg.ticks = 19'd533;     end
         5'd7:          begin seg.level = 1'b1; seg.ticks = 19'd560;     end
         5'd8:          begin seg.level = 1'b1; seg.ticks = 19'd39466;   end
         5'd9:          begin seg.level = 1'b0; seg.ticks = 19'd8877;    end
         5'd10:         begin seg.level = 1'b1; seg.ticks = 19'd2250;    end
         5'd11:         begin seg.level = 1'b0; seg.ticks = 19'd533;     end
         5'd12:         begin seg.level = 1'b1; seg.ticks = 19'd560;     end
         5'd13:         begin seg.level = 1'b1; seg.ticks = 19'd95000;   end
         5'd14:         begin seg.level = 1'b0; seg.ticks = 19'd8877;    end
         5'd15:         begin seg.level = 1'b1; seg.ticks = 19'd2250;    end
         5'd16:         begin seg.level = 1'b0; seg.ticks = 19'd533;     end
         5'd17:         begin seg.level = 1'b1; seg.ticks = 19'd560;     end
         PH_TAIL_LAST:  begin seg.level = 1'b1; seg.ticks = 19'd273000;  end
         default: begin
            seg.phase = PH_IDLE;
            seg.level = 1'b1;
            seg.ticks = '0;
         end
      endcase
      return seg;
   endfunction

endpackage

>>> rtl/irt_sequencer.sv
// Segment sequencer: frame, bit position, phase and tick counter with their next-state logic.
module irt_sequencer
   import irt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_accept,
   input  logic                 cmd,
   input  logic [KEY_WIDTH-1:0] key_code,
   output irt_result_type       result
);

   logic [FRAME_LEN-1:0]   frame_ff,  frame_in;
   logic [POS_WIDTH-1:0]   pos_ff,    pos_in;
   logic [PHASE_WIDTH-1:0] phase_ff,  phase_in;
   logic [TICK_WIDTH-1:0]  ticks_ff,  ticks_in;
   logic                   line_ff,   line_in;

   logic [POS_WIDTH-1:0]   pos_next;
   logic [TICK_WIDTH-1:0]  ticks_dec;
   logic                   key_bad;
   logic                   rejected;
   irt_segment_type        seg;

   // Frame bit at a position, counted from the most significant bit, position taken modulo 48.
   function automatic logic bit_at(input logic [FRAME_LEN-1:0] frame,
                                   input logic [POS_WIDTH-1:0] pos);
      logic [POS_WIDTH-1:0] idx;
      idx = (pos >= POS_WIDTH'(FRAME_LEN)) ? pos - POS_WIDTH'(FRAME_LEN) : pos;
      return frame[POS_WIDTH'(FRAME_LEN - 1) - idx];
   endfunction

   assign pos_next  = pos_ff + 1'b1;
   assign ticks_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;
   assign key_bad   = {1'b0, key_code} >= 6'(KEY_COUNT);

   always_comb begin
      frame_in = frame_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      line_in  = line_ff;
      rejected = 1'b0;
      seg      = enter_phase(PH_IDLE);
      if (item_accept) begin
         if (cmd) begin
            if (phase_ff != PH_IDLE || key_bad) begin
               rejected = 1'b1;
            end else begin
               frame_in = {PREAMBLE, key_bytes(key_code)};
               pos_in   = '0;
               seg      = enter_phase(PH_START_LOW);
               phase_in = seg.phase;
               ticks_in = seg.ticks;
               line_in  = seg.level;
            end
         end else if (phase_ff != PH_IDLE) begin
            ticks_in = ticks_dec;
            if (ticks_dec == '0) begin
               case (phase_ff)
                  PH_START_LOW:  seg = enter_phase(PH_START_HIGH);
                  PH_START_HIGH: seg = enter_phase(bit_at(frame_ff, pos_ff) ?
                                                   PH_ONE_LOW : PH_ZERO_HIGH);
                  PH_ONE_LOW:    seg = enter_phase(PH_ONE_HIGH);
                  PH_ONE_HIGH, PH_ZERO_HIGH: begin
                     pos_in = pos_next;
                     if (pos_next >= POS_WIDTH'(FRAME_LEN)) begin
                        seg = enter_phase(PH_TAIL_FIRST);
                     end else begin
                        seg = enter_phase(bit_at(frame_ff, pos_next) ?
                                          PH_ONE_LOW : PH_ZERO_HIGH);
                     end
                  end
                  default: begin
                     if (phase_ff >= PH_TAIL_FIRST && phase_ff < PH_TAIL_LAST) begin
                        seg = enter_phase(phase_ff + 1'b1);
                     end else begin
                        seg = enter_phase(PH_IDLE);
                     end
                  end
               endcase
               phase_in = seg.phase;
               ticks_in = seg.ticks;
               line_in  = seg.level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pos_ff   <= '0;
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         line_ff  <= 1'b1;
      end else begin
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         line_ff  <= line_in;
      end
   end

   // Result reflects the state after this transaction's update.
   assign result.line_level = line_in;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.rejected   = rejected;

endmodule

>>> rtl/ir_remote_frame_transmitter.sv
// Top level of the IR remote frame transmitter: stream ports and the result register.
//
// The block plays a pulse-distance remote-control frame as a series of line levels, one
// result per input transaction. A transaction with tuser low is a one-microsecond tick; a
// transaction with tuser high starts a frame for the key code in tdata. The frame is a start
// pulse, three preamble bytes, the three table bytes of the key (most significant bit first)
// and a fixed stop and repeat tail ending in 273 ms of high level; the line idles high. A send
// while a frame is running, or with a key code of 22 or more, is refused and flagged in its
// result. The state update and the result are formed in the same cycle from the registered
// state and written to the result register, so a new transaction is accepted every cycle
// while the result side keeps up, and the result appears on the next cycle. The result
// register also decouples the two sides: input is taken whenever the result register is
// empty or its contents are being taken in the same cycle.
module ir_remote_frame_transmitter
   import irt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] key_code, [7:5] zero
   input  logic       req_tuser,   // [0] cmd: 0 tick, 1 send
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] line_level, [1] busy_res, [2] rejected, [7:3] zero
);

   logic           req_accept;
   irt_result_type result;

   logic           rsp_valid_ff, rsp_valid_in;
   irt_result_type rsp_data_ff,  rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   irt_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .cmd         (req_tuser),
      .key_code    (req_tdata[KEY_WIDTH-1:0]),
      .result      (result)
   );

   // Result register: loaded on every accepted transaction, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff.rejected, rsp_data_ff.busy_res,
                        rsp_data_ff.line_level};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the IR remote frame transmitter.
`timescale 1ns / 100ps

module testbench
   import irt_pkg::*;
;

   // The block is tested through its two stream ports. An initial block fills a queue of
   // pending commands. A clocked driver presents them on the request channel, and random
   // idle bursts break up the flow. Every accepted transaction is run through a local
   // model of the transmitter, and the result that the model predicts joins a queue of
   // expected line levels. A clocked monitor takes results at random and compares each
   // one, field by field, with the oldest prediction.
   //
   // A full frame takes about half a million ticks, far more than this run sends, so the
   // stimulus covers the start of a frame only. The directed part starts the frame for key
   // code zero. The random part that follows keeps ticking that frame, and the sends
   // scattered through it show that a busy transmitter refuses them.

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   localparam int RANDOM_ITEMS = 1450;
   localparam int FINAL_ITEMS  = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic                 cmd;
      logic [KEY_WIDTH-1:0] key;
   } ir_command_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tuser  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   ir_command_type pending_cmds[$];
   irt_result_type level_expected[$];
   ir_command_type req_item;

   int cycle_count  = 0;
   int fail_count   = 0;
   int result_count = 0;
   int req_gap      = 0;
   int rsp_gap      = 0;
   int req_rate     = 0;
   int rsp_rate     = 0;
   bit idling_on    = 1'b1;

   // State of the local transmitter model.
   logic [FRAME_LEN-1:0]   tx_frame     = '0;
   logic [POS_WIDTH-1:0]   tx_bits_sent = '0;
   logic [PHASE_WIDTH-1:0] tx_phase     = PH_IDLE;
   logic [TICK_WIDTH-1:0]  tx_ticks     = '0;
   logic                   tx_line      = 1'b1;

   ir_remote_frame_transmitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // The three key bytes that follow the preamble.
   function automatic logic [23:0] key_pattern(input logic [KEY_WIDTH-1:0] code);
      logic [23:0] bytes;
      case (code)
         5'd0:    bytes = 24'hffaaaa;
         5'd1:    bytes = 24'hb7bb56;
         5'd2:    bytes = 24'hd7b756;
         5'd3:    bytes = 24'habdf56;
         5'd4:    bytes = 24'hef6b56;
         5'd5:    bytes = 24'hfed556;
         5'd6:    bytes = 24'hafbd56;
         5'd7:    bytes = 24'habfeaa;
         5'd8:    bytes = 24'hb6fb6a;
         5'd9:    bytes = 24'hbbf5aa;
         5'd10:   bytes = 24'hd6f76a;
         5'd11:   bytes = 24'hbafaea;
         5'd12:   bytes = 24'hb5fbaa;
         5'd13:   bytes = 24'hebebaa;
         5'd14:   bytes = 24'hf5eaea;
         5'd15:   bytes = 24'hd56df6;
         5'd16:   bytes = 24'hf7d5aa;
         5'd17:   bytes = 24'heaf5ea;
         5'd18:   bytes = 24'hdadb76;
         5'd19:   bytes = 24'hdf6d56;
         5'd20:   bytes = 24'hddb6b6;
         5'd21:   bytes = 24'hdbb6d6;
         default: bytes = 24'h000000;
      endcase
      return bytes;
   endfunction

   // Level and length of each segment of the stop and repeat tail, as {level, ticks}.
   function automatic logic [TICK_WIDTH:0] tail_segment(input logic [3:0] idx);
      logic [TICK_WIDTH:0] seg;
      case (idx)
         4'd0:    seg = {1'b0, 19'd533};
         4'd1:    seg = {1'b1, 19'd560};
         4'd2:    seg = {1'b1, 19'd39466};
         4'd3:    seg = {1'b0, 19'd8877};
         4'd4:    seg = {1'b1, 19'd2250};
         4'd5:    seg = {1'b0, 19'd533};
         4'd6:    seg = {1'b1, 19'd560};
         4'd7:    seg = {1'b1, 19'd95000};
         4'd8:    seg = {1'b0, 19'd8877};
         4'd9:    seg = {1'b1, 19'd2250};
         4'd10:   seg = {1'b0, 19'd533};
         4'd11:   seg = {1'b1, 19'd560};
         default: seg = {1'b1, 19'd273000};
      endcase
      return seg;
   endfunction

   function automatic void park_line();
      tx_phase = PH_IDLE;
      tx_ticks = '0;
      tx_line  = 1'b1;
   endfunction

   function automatic void load_segment(input logic [PHASE_WIDTH-1:0] phase);
      tx_phase = phase;
      case (phase)
         PH_START_LOW:  begin tx_line = 1'b0; tx_ticks = 19'd8885; end
         PH_START_HIGH: begin tx_line = 1'b1; tx_ticks = 19'd4456; end
         PH_ONE_LOW:    begin tx_line = 1'b0; tx_ticks = 19'd533;  end
         PH_ONE_HIGH:   begin tx_line = 1'b1; tx_ticks = 19'd560;  end
         PH_ZERO_HIGH:  begin tx_line = 1'b1; tx_ticks = 19'd1093; end
         default: begin
            if (phase >= PH_TAIL_FIRST && phase <= PH_TAIL_LAST) begin
               {tx_line, tx_ticks} = tail_segment(4'(phase - PH_TAIL_FIRST));
            end else begin
               park_line();
            end
         end
      endcase
   endfunction

   // Bits go out most significant first: a one starts low, a zero is one long high.
   function automatic void next_bit();
      if (tx_frame[POS_WIDTH'(FRAME_LEN - 1) - tx_bits_sent]) begin
         load_segment(PH_ONE_LOW);
      end else begin
         load_segment(PH_ZERO_HIGH);
      end
   endfunction

   function automatic void advance_segment();
      case (tx_phase)
         PH_START_LOW:  load_segment(PH_START_HIGH);
         PH_START_HIGH: next_bit();
         PH_ONE_LOW:    load_segment(PH_ONE_HIGH);
         PH_ONE_HIGH, PH_ZERO_HIGH: begin
            tx_bits_sent = tx_bits_sent + 1'b1;
            if (tx_bits_sent >= FRAME_LEN) begin
               load_segment(PH_TAIL_FIRST);
            end else begin
               next_bit();
            end
         end
         default: begin
            if (tx_phase >= PH_TAIL_FIRST && tx_phase < PH_TAIL_LAST) begin
               load_segment(tx_phase + 1'b1);
            end else begin
               park_line();
            end
         end
      endcase
   endfunction

   // Applies one accepted transaction to the model and returns the result that it causes.
   function automatic irt_result_type predict_level(input ir_command_type c);
      irt_result_type r;
      r.rejected = 1'b0;
      if (c.cmd == CMD_SEND) begin
         if (tx_phase != PH_IDLE || c.key >= KEY_COUNT) begin
            r.rejected = 1'b1;
         end else begin
            tx_frame     = {PREAMBLE, key_pattern(c.key)};
            tx_bits_sent = '0;
            load_segment(PH_START_LOW);
         end
      end else if (tx_phase != PH_IDLE) begin
         if (tx_ticks != 0) begin
            tx_ticks = tx_ticks - 1'b1;
         end
         if (tx_ticks == 0) begin
            advance_segment();
         end
      end
      r.line_level = tx_line;
      r.busy_res   = (tx_phase != PH_IDLE);
      return r;
   endfunction

   function automatic int pick_stall_rate();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 7;
         default: return 31;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // The cycle counter also picks new idling rates for each side as the run goes on, so
   // that busy stretches and stretches without any idling alternate.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 2048 == 0) begin
         req_rate <= pick_stall_rate();
         rsp_rate <= pick_stall_rate();
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Request driver. A transaction stays on the bus until it is accepted; idle bursts only
   // begin once the bus is free.
   always @(posedge clock) begin : drive_requests
      ir_command_type next_cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            level_expected.push_back(predict_level(req_item));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idling_on && req_rate != 0 && $urandom_range(req_rate) == 0) begin
               req_gap    <= $urandom_range(6);
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               next_cmd = pending_cmds.pop_front();
               req_item   <= next_cmd;
               req_tdata  <= {3'b000, next_cmd.key};
               req_tuser  <= next_cmd.cmd;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and its back-pressure.
   always @(posedge clock) begin : check_results
      irt_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (level_expected.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no transaction waiting",
                                         result_count));
            end else begin
               want = level_expected.pop_front();
               if (rsp_tdata[0] !== want.line_level) begin
                  report_mismatch($sformatf("result %0d line_level expected %0b got %0b",
                                            result_count, want.line_level, rsp_tdata[0]));
               end
               if (rsp_tdata[1] !== want.busy_res) begin
                  report_mismatch($sformatf("result %0d busy_res expected %0b got %0b",
                                            result_count, want.busy_res, rsp_tdata[1]));
               end
               if (rsp_tdata[2] !== want.rejected) begin
                  report_mismatch($sformatf("result %0d rejected expected %0b got %0b",
                                            result_count, want.rejected, rsp_tdata[2]));
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap    <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && rsp_rate != 0 && $urandom_range(rsp_rate) == 0) begin
            rsp_gap    <= $urandom_range(6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic cmd, input logic [KEY_WIDTH-1:0] code);
      ir_command_type c;
      c.cmd = cmd;
      c.key = code;
      pending_cmds.push_back(c);
   endtask

   // Mostly ticks, with one send in six; the key field is random on ticks as well.
   task automatic push_random_item();
      if ($urandom_range(5) == 0) begin
         push_item(CMD_SEND, KEY_WIDTH'($urandom_range(31)));
      end else begin
         push_item(CMD_TICK, KEY_WIDTH'($urandom_range(31)));
      end
   endtask

   // Waits at falling edges until every command has been accepted and every result taken.
   task automatic wait_settled();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || level_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      @(negedge reset);

      // Ticks while idle, then refused key codes at the bottom and top of the invalid range.
      push_item(CMD_TICK, 5'd0);
      push_item(CMD_TICK, 5'd31);
      push_item(CMD_SEND, 5'd22);
      push_item(CMD_SEND, 5'd31);
      // Key code zero sends the preamble bytes twice; everything after it finds the line busy.
      push_item(CMD_SEND, 5'd0);
      push_item(CMD_SEND, 5'd21);
      push_item(CMD_SEND, 5'd0);
      push_item(CMD_SEND, 5'd31);
      repeat (8) push_item(CMD_TICK, KEY_WIDTH'($urandom_range(31)));
      push_item(CMD_SEND, 5'd5);
      push_item(CMD_TICK, 5'd10);

      // Hold the sender back until the block has delivered every outstanding result.
      wait_settled();

      // Random part: the frame keeps running and every send in it is refused.
      repeat (RANDOM_ITEMS) push_random_item();
      wait_settled();

      // Closing stretch at full rate on both sides.
      idling_on = 1'b0;
      repeat (FINAL_ITEMS) push_random_item();

      wait_settled();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/irt_pkg.sv
rtl/irt_sequencer.sv
rtl/ir_remote_frame_transmitter.sv
tb/testbench.sv
